/* rtl/wrg_pkg.sv */
// shared types, codes and cell rule functions for the wireworld raster unit
package wrg_pkg;

    localparam int CELL_W  = 2;
    localparam int COORD_W = 10;
    localparam int DIM_W   = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CELL_W-1:0] CELL_EMPTY     = 2'd0;
    localparam logic [CELL_W-1:0] CELL_CONDUCTOR = 2'd1;
    localparam logic [CELL_W-1:0] CELL_HEAD      = 2'd2;
    localparam logic [CELL_W-1:0] CELL_TAIL      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

    typedef logic [CELL_W-1:0] cell_t;

    typedef struct packed {
        logic               last_of_frame;
        logic               changed;
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        cell_t              new_state;
    } result_t;

    function automatic logic [3:0] head_bit(input cell_t s);
        head_bit = (s == CELL_HEAD) ? 4'd1 : 4'd0;
    endfunction

    function automatic cell_t wire_rule(input cell_t centre, input logic [3:0] heads);
        cell_t r;
        unique case (centre)
            CELL_HEAD:      r = CELL_TAIL;
            CELL_TAIL:      r = CELL_CONDUCTOR;
            CELL_CONDUCTOR: r = (heads == 4'd1 || heads == 4'd2) ? CELL_HEAD : CELL_CONDUCTOR;
            default:        r = CELL_EMPTY;
        endcase
        wire_rule = r;
    endfunction

endpackage

/* rtl/wireworld_raster_generation_unit.sv */
// wireworld generation over a raster-streamed grid with a line memory
// Usage: cells enter on s_axis (tdata[1:0] = cell state) in raster order, grid_height rows
// of grid_width cells followed by one padding row of grid_width items. Results leave on
// m_axis, one per cell of the frame, each with its coordinates, a changed flag and tlast on
// the frame's final cell. The result for cell (r, c) follows the item at (r+1, c+1); the
// last column of a row is released together with the item at (r+1, width-1).
// Throughput: one item per cycle unless the update stage waits. The line memory is read at
// the accepting edge and the update stage works in the cycle after it, pushing into a
// 4-entry output queue; a result is registered in the queue when the stage fires and is
// offered on m_axis from there. The update stage pushes up to two results per item; it
// waits while the queue lacks room, and s_axis_tready drops then.
// Both stored rows share one memory word per column, read at accept and written back from
// the update stage; a read that meets a write to the same column takes the written word.
// Width 1 makes every item hit the same column, which this path covers.
// Configuration: cfg_valid/cfg_ready (always ready) writes grid_width (index 0) or
// grid_height (index 1); a value of 0 acts as 1 and one above the maximum acts as the max.
// Reset clears counters, the column window and the queue; the line memory needs no clear
// since entries of rows not yet seen are masked by the row counter.
module wireworld_raster_generation_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [1:0] cell_state
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [23:0]                   m_axis_tdata,   // new_state, out_col, out_row, changed
    output logic                          m_axis_tlast,   // last_of_frame
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wrg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wrg_pkg::DIM_W-1:0]     cfg_data
);

    localparam int IDXW  = $clog2(MAX_WIDTH);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int QD    = 4;

    // configuration
    logic [wrg_pkg::DIM_W-1:0] width_reg, height_reg;
    logic [CW-1:0] w_eff;
    logic [RW-1:0] h_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd64;
            height_reg <= 11'd64;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                wrg_pkg::REG_GRID_WIDTH:  width_reg  <= cfg_data;
                wrg_pkg::REG_GRID_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            w_eff = CW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(width_reg);
        if (height_reg == '0)
            h_eff = RW'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            h_eff = RW'(MAX_HEIGHT);
        else
            h_eff = RW'(height_reg);
    end

    // accept side: counters and memory read
    logic [IDXW-1:0] col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic            accept;
    logic            last_col, padding, active;
    wrg_pkg::cell_t  cur;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign last_col = (32'(col_reg) + 32'd1) >= 32'(w_eff);
    assign padding  = 32'(row_reg) >= 32'(h_eff);
    assign active   = (row_reg != '0) && (32'(row_reg) <= 32'(h_eff));
    assign cur      = padding ? wrg_pkg::CELL_EMPTY : s_axis_tdata[1:0];

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (last_col)
        begin
            col_next = '0;
            row_next = padding ? '0 : RW'(32'(row_reg) + 32'd1);
        end
        else
        begin
            col_next = IDXW'(32'(col_reg) + 32'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line memory: {row two above, row one above} per column
    logic [3:0]      line_mem [MAX_WIDTH];
    logic [3:0]      rd_data_reg;
    logic [3:0]      wr_data;
    logic            s1_fire;

    // update stage registers
    logic            s1_valid_reg;
    logic [IDXW-1:0] s1_col_reg;
    logic [RW-1:0]   s1_row_reg;
    logic            s1_last_col_reg, s1_active_reg, s1_last_row_reg;
    wrg_pkg::cell_t  s1_cur_reg;
    logic            s1_fwd_reg;
    logic [3:0]      s1_fwd_data_reg;
    logic            s1_first;

    assign s1_first = (s1_col_reg == '0);

    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= line_mem[col_reg];
        if (s1_fire)
            line_mem[s1_col_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg      <= col_reg;
            s1_row_reg      <= row_reg;
            s1_last_col_reg <= last_col;
            s1_active_reg   <= active;
            s1_last_row_reg <= 32'(row_reg) == 32'(h_eff);
            s1_cur_reg      <= cur;
            // write back in flight to the column being read
            s1_fwd_reg      <= s1_fire && (s1_col_reg == col_reg);
            s1_fwd_data_reg <= wr_data;
        end
    end

    // column window: mid is column j-1, left is column j-2
    wrg_pkg::cell_t win_m_reg [3];
    wrg_pkg::cell_t win_l_reg [3];
    wrg_pkg::cell_t md [3];
    wrg_pkg::cell_t lt [3];
    wrg_pkg::cell_t ct [3];
    logic [3:0]     mem_word;
    logic [3:0]     heads_a, heads_b;
    logic           res_a_valid, res_b_valid;
    wrg_pkg::result_t res_a, res_b;
    logic [1:0]     push_cnt;

    assign mem_word = s1_fwd_reg ? s1_fwd_data_reg : rd_data_reg;
    assign wr_data  = {mem_word[1:0], s1_cur_reg};

    always_comb
    begin
        ct[0] = (32'(s1_row_reg) >= 32'd2) ? mem_word[3:2] : wrg_pkg::CELL_EMPTY;
        ct[1] = (s1_row_reg != '0) ? mem_word[1:0] : wrg_pkg::CELL_EMPTY;
        ct[2] = s1_cur_reg;
        for (int k = 0; k < 3; k++)
        begin
            md[k] = s1_first ? wrg_pkg::CELL_EMPTY : win_m_reg[k];
            lt[k] = s1_first ? wrg_pkg::CELL_EMPTY : win_l_reg[k];
        end
    end

    always_comb
    begin
        heads_a = wrg_pkg::head_bit(lt[0]) + wrg_pkg::head_bit(lt[1])
                + wrg_pkg::head_bit(lt[2]) + wrg_pkg::head_bit(md[0])
                + wrg_pkg::head_bit(md[2]) + wrg_pkg::head_bit(ct[0])
                + wrg_pkg::head_bit(ct[1]) + wrg_pkg::head_bit(ct[2]);
        // closing cell of a row: right neighbours lie outside the grid
        heads_b = wrg_pkg::head_bit(md[0]) + wrg_pkg::head_bit(md[1])
                + wrg_pkg::head_bit(md[2]) + wrg_pkg::head_bit(ct[0])
                + wrg_pkg::head_bit(ct[2]);

        res_a_valid = s1_active_reg && !s1_first;
        res_b_valid = s1_active_reg && s1_last_col_reg;

        res_a.new_state     = wrg_pkg::wire_rule(md[1], heads_a);
        res_a.out_col       = wrg_pkg::COORD_W'(32'(s1_col_reg) - 32'd1);
        res_a.out_row       = wrg_pkg::COORD_W'(32'(s1_row_reg) - 32'd1);
        res_a.changed       = res_a.new_state != md[1];
        res_a.last_of_frame = 1'b0;

        res_b.new_state     = wrg_pkg::wire_rule(ct[1], heads_b);
        res_b.out_col       = wrg_pkg::COORD_W'(s1_col_reg);
        res_b.out_row       = wrg_pkg::COORD_W'(32'(s1_row_reg) - 32'd1);
        res_b.changed       = res_b.new_state != ct[1];
        res_b.last_of_frame = s1_last_row_reg;

        push_cnt = {1'b0, res_a_valid} + {1'b0, res_b_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_m_reg[k] <= wrg_pkg::CELL_EMPTY;
                win_l_reg[k] <= wrg_pkg::CELL_EMPTY;
            end
        end
        else if (s1_fire)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_l_reg[k] <= md[k];
                win_m_reg[k] <= ct[k];
            end
        end
    end

    // output queue
    wrg_pkg::result_t q_mem [QD];
    logic [1:0] wptr_reg, rptr_reg;
    logic [2:0] count_reg, count_next;
    logic       pop;
    logic [2:0] free;
    wrg_pkg::result_t q_head;

    assign free    = 3'(QD) - count_reg;
    assign s1_fire = s1_valid_reg && (free >= {1'b0, push_cnt});
    assign s_axis_tready = !s1_valid_reg || s1_fire;

    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = count_reg != '0;
    assign q_head        = q_mem[rptr_reg];
    assign m_axis_tdata  = {1'b0, q_head.changed, q_head.out_row, q_head.out_col,
                            q_head.new_state};
    assign m_axis_tlast  = q_head.last_of_frame;

    assign count_next = count_reg + (s1_fire ? {1'b0, push_cnt} : 3'd0) - {2'b0, pop};

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            priority if (res_a_valid)
            begin
                q_mem[wptr_reg] <= res_a;
                if (res_b_valid)
                    q_mem[wptr_reg + 2'd1] <= res_b;
            end
            else if (res_b_valid)
            begin
                q_mem[wptr_reg] <= res_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (s1_fire)
                wptr_reg <= wptr_reg + push_cnt;
            if (pop)
                rptr_reg <= rptr_reg + 2'd1;
            count_reg <= count_next;
        end
    end

    // checks
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 3'(QD))
        else $error("output queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n) accept |=> s1_valid_reg)
        else $error("accepted item lost before update stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_col_reg) && $stable(s1_row_reg))
        else $error("stalled update stage changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && res_b_valid |-> s1_last_col_reg && s1_active_reg)
        else $error("row end result without row end");

endmodule
